// File: rtl/ipv4hf_pkg.sv
// Package for the IPv4 header fragmenter: payload types, header constants,
// configuration register indexes and the fragment size helper.
// No dependencies.
package ipv4hf_pkg;

    // Datagram limits and header layout
    localparam int          MAX_DATAGRAM = 65535;
    localparam int          HDR_LEN      = 20;
    localparam int          IDX_W        = $clog2(HDR_LEN + 1);
    localparam logic [IDX_W-1:0] PAY_IDX = IDX_W'(HDR_LEN);

    localparam logic [7:0]  VER_IHL      = 8'h45;
    localparam logic [7:0]  TTL_DEFAULT  = 8'd64;
    localparam logic [15:0] DF_FLAG      = 16'h4000;
    localparam logic [15:0] MF_FLAG      = 16'h2000;
    localparam logic [15:0] MTU_RESET    = 16'd1500;
    localparam logic [15:0] MTU_MIN_SPLIT = 16'd28;
    localparam logic [15:0] TINY_FRAG    = 16'd8;

    // Configuration register indexes
    localparam int          CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MTU    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_IP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_IP = 2'd2;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] segment_length;
        logic [7:0]  upper_protocol;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       fragment_end;
        logic       run_last;
        logic       oversize_error;
    } t_out_item;

    // One item's work handed from the control stage to the emitter
    typedef struct packed {
        logic        has_hdr;
        logic        err;
        logic [7:0]  data;
        logic        fend;
        logic [15:0] total;
        logic [15:0] ident;
        logic [15:0] flags;
        logic [7:0]  proto;
    } t_job;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
    } t_addr;

    // Payload bytes per fragment for a given MTU, multiple of 8
    function automatic logic [15:0] frag_size(input logic [15:0] mtu);
        logic [15:0] d;
        d = mtu - 16'(HDR_LEN);
        return (mtu >= MTU_MIN_SPLIT) ? {d[15:3], 3'b000} : TINY_FRAG;
    endfunction

endpackage

// File: rtl/ipv4_header_fragmenter_core.sv
// Top level of the IPv4 header fragmenter: control stage feeding the
// header/payload emitter. Depends on ipv4hf_pkg, ipv4hf_ctrl, ipv4hf_emit.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------
//  input    | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  output   | o_out_valid / i_out_ready | o_out_data (t_out_item)
//  config   | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// A payload byte that continues a fragment gives one output transaction and
// the block takes one such byte per cycle while the output does not stall. A
// byte that opens a fragment gives 21 transactions, one per cycle while the
// output does not stall, set by the single output byte lane.
// Reset is synchronous, active low; it restores MTU 1500 and identifier 1.
// Output stalls back up through the emitter and the job register to o_in_ready.
module ipv4_header_fragmenter_core import ipv4hf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data
);

    logic  job_valid, take;
    t_job  job;
    t_addr addr;

    // Decisions and segment state
    ipv4hf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_take      (take),
        .o_job_valid (job_valid),
        .o_job       (job),
        .o_addr      (addr)
    );

    // Header build and byte output
    ipv4hf_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .i_addr      (addr),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/ipv4hf_ctrl.sv
// Control stage: configuration registers, segment/fragment tracking and
// per-item decisions, registered into one job. Depends on ipv4hf_pkg.
module ipv4hf_ctrl import ipv4hf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    input  logic                 i_take,
    output logic                 o_job_valid,
    output t_job                 o_job,
    output t_addr                o_addr
);

    logic [15:0] r_mtu, r_fragsize;
    logic [31:0] r_src_ip, r_dst_ip;
    logic [15:0] r_ident_ctr, r_dgram_ident, r_pos, r_fill;
    logic        r_dropping;
    logic        r_job_valid;
    t_job        r_job;

    logic [15:0] len, remaining, fl, flags, ident;
    logic [16:0] len_hdr;
    logic        first, seg_end, oversize, drop, fragmenting, mf, fend, accept;
    t_job        n_job;

    assign o_in_ready  = !r_job_valid || i_take;
    assign accept      = i_in_valid && o_in_ready;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;
    assign o_addr      = '{src_ip: r_src_ip, dst_ip: r_dst_ip};

    // Per-item decisions
    always_comb begin
        len      = (i_in_data.segment_length == 16'd0) ? 16'd1 : i_in_data.segment_length;
        len_hdr  = {1'b0, len} + 17'(HDR_LEN);
        first    = (r_pos == 16'd0);
        seg_end  = ({1'b0, r_pos} + 17'd1) >= {1'b0, len};
        oversize = len_hdr > 17'(MAX_DATAGRAM);
        drop     = first ? oversize : r_dropping;
        ident    = first ? r_ident_ctr : r_dgram_ident;
        fragmenting = {1'b0, r_mtu} < len_hdr;
        remaining   = (r_pos < len) ? (len - r_pos) : 16'd1;
        mf          = fragmenting && (remaining > r_fragsize);
        if (first && !fragmenting) begin
            flags = DF_FLAG;
            fl    = remaining;
        end else begin
            fl    = mf ? r_fragsize : remaining;
            flags = (mf ? MF_FLAG : 16'd0) | {3'b000, r_pos[15:3]};
        end
        fend = seg_end ||
               (fragmenting && (({1'b0, r_fill} + 17'd1) >= {1'b0, r_fragsize}));

        n_job.has_hdr = !drop && (r_fill == 16'd0);
        n_job.err     = drop;
        n_job.data    = drop ? 8'd0 : i_in_data.payload_byte;
        n_job.fend    = !drop && fend;
        n_job.total   = fl + 16'(HDR_LEN);
        n_job.ident   = ident;
        n_job.flags   = flags;
        n_job.proto   = i_in_data.upper_protocol;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu      <= MTU_RESET;
            r_fragsize <= frag_size(MTU_RESET);
            r_src_ip   <= '0;
            r_dst_ip   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MTU: begin
                    r_mtu      <= i_cfg_data[15:0];
                    r_fragsize <= frag_size(i_cfg_data[15:0]);
                end
                CFG_SRC_IP: r_src_ip <= i_cfg_data;
                CFG_DST_IP: r_dst_ip <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Segment state and job valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ident_ctr   <= 16'd1;
            r_dgram_ident <= '0;
            r_pos         <= '0;
            r_fill        <= '0;
            r_dropping    <= 1'b0;
            r_job_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_dropping <= drop && !seg_end;
                r_pos      <= seg_end ? 16'd0 : r_pos + 16'd1;
                if (!drop) begin
                    r_dgram_ident <= ident;
                    if (r_fill == 16'd0) begin
                        r_ident_ctr <= r_ident_ctr + 16'd1;
                    end
                    r_fill <= (fend || seg_end) ? 16'd0 : r_fill + 16'd1;
                end else if (seg_end) begin
                    r_fill <= 16'd0;
                end
                // an item of a dropped segment past its first byte gives nothing
                r_job_valid <= !drop || first;
            end else if (i_take) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

// File: rtl/ipv4hf_emit.sv
// Emitter: computes the header checksum when it takes a job, then sends the
// 20 header bytes (only for a job that opens a fragment) and the payload byte through an output register.
// Depends on ipv4hf_pkg.
module ipv4hf_emit import ipv4hf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    input  t_addr     i_addr,
    output logic      o_take,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic [7:0]       r_hdr [HDR_LEN];
    logic [7:0]       r_data;
    logic             r_fend, r_err;
    logic [IDX_W-1:0] r_idx;
    logic             r_busy;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [19:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2, csum;
    logic [7:0]  n_hdr [HDR_LEN];
    logic        out_free, last_now;
    t_out_item   n_out;

    assign out_free    = !r_out_valid || i_out_ready;
    assign last_now    = r_busy && out_free && (r_idx == PAY_IDX);
    assign o_take      = i_job_valid && (!r_busy || last_now);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Ones'-complement header checksum, folded twice
    always_comb begin
        sum = 20'({VER_IHL, 8'h00}) + 20'(i_job.total) + 20'(i_job.ident)
            + 20'(i_job.flags) + 20'({TTL_DEFAULT, i_job.proto})
            + 20'(i_addr.src_ip[31:16]) + 20'(i_addr.src_ip[15:0])
            + 20'(i_addr.dst_ip[31:16]) + 20'(i_addr.dst_ip[15:0]);
        fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
        fold2 = fold1[15:0] + 16'(fold1[16]);
        csum  = ~fold2;
    end

    // Header bytes in transmit order
    always_comb begin
        n_hdr[0]  = VER_IHL;
        n_hdr[1]  = 8'h00;
        n_hdr[2]  = i_job.total[15:8];
        n_hdr[3]  = i_job.total[7:0];
        n_hdr[4]  = i_job.ident[15:8];
        n_hdr[5]  = i_job.ident[7:0];
        n_hdr[6]  = i_job.flags[15:8];
        n_hdr[7]  = i_job.flags[7:0];
        n_hdr[8]  = TTL_DEFAULT;
        n_hdr[9]  = i_job.proto;
        n_hdr[10] = csum[15:8];
        n_hdr[11] = csum[7:0];
        n_hdr[12] = i_addr.src_ip[31:24];
        n_hdr[13] = i_addr.src_ip[23:16];
        n_hdr[14] = i_addr.src_ip[15:8];
        n_hdr[15] = i_addr.src_ip[7:0];
        n_hdr[16] = i_addr.dst_ip[31:24];
        n_hdr[17] = i_addr.dst_ip[23:16];
        n_hdr[18] = i_addr.dst_ip[15:8];
        n_hdr[19] = i_addr.dst_ip[7:0];
    end

    // Next result transaction
    always_comb begin
        if (r_idx == PAY_IDX) begin
            n_out = '{out_byte: r_data, fragment_end: r_fend, run_last: 1'b1,
                      oversize_error: r_err};
        end else begin
            n_out = '{out_byte: r_hdr[r_idx], fragment_end: 1'b0, run_last: 1'b0,
                      oversize_error: 1'b0};
        end
    end

    // Sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_busy;
            end
            if (o_take) begin
                r_busy <= 1'b1;
                r_idx  <= i_job.has_hdr ? '0 : PAY_IDX;
            end else if (last_now) begin
                r_busy <= 1'b0;
            end else if (r_busy && out_free) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (out_free && r_busy) begin
            r_out <= n_out;
        end
        if (o_take) begin
            r_hdr  <= n_hdr;
            r_data <= i_job.data;
            r_fend <= i_job.fend;
            r_err  <= i_job.err;
        end
    end

endmodule
